>>> sv/takeover_control_supervisor_top_defines.svh
// assertion macros for the takeover control supervisor
`ifndef TAKEOVER_CONTROL_SUPERVISOR_TOP_DEFINES_SVH
`define TAKEOVER_CONTROL_SUPERVISOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define TCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TCS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCS_ASSERT(lbl, prop, msg)
`define TCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/tcs_pkg.sv
// types and constants shared by the takeover control supervisor
package tcs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int AW_W = FRAC_BITS + 1;
	localparam logic [AW_W-1:0] AW_ONE = AW_W'(1) << FRAC_BITS;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_STEPS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_PER_TICK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_AWARENESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL_PER_TICK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_AUTOMATED   = 3'd4;

	typedef enum logic [2:0] {
		MODE_MANUAL  = 3'd0,
		MODE_AUTO    = 3'd1,
		MODE_PREP    = 3'd2,
		MODE_BRAKE   = 3'd3,
		MODE_RECOVER = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_TAKEOVER = 2'd1,
		OP_BRAKE    = 2'd2,
		OP_SET_AW   = 2'd3
	} op_t;

	typedef struct packed {
		op_t             opcode;
		logic [15:0]     time_till_brake;
		logic [16:0]     awareness_value;
		logic [15:0]     current_speed;
	} tcs_in_t;

	typedef struct packed {
		mode_t           mode;
		logic [16:0]     awareness;
		logic            automated_type;
		logic            speed_cmd_valid;
		logic [15:0]     speed_cmd;
		logic            warning;
	} tcs_out_t;

	typedef struct packed {
		logic [15:0]     response_steps;
		logic [AW_W-1:0] recovery_per_tick;
		logic [AW_W-1:0] initial_awareness;
		logic [15:0]     decel_per_tick;
		logic            start_automated;
		logic            restart;
		logic            restart_auto;
	} tcs_cfg_t;

endpackage

>>> sv/tcs_cfg.sv
// configuration registers and mode restart request
module tcs_cfg
	import tcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output tcs_cfg_t             cfg
);

	logic [15:0]     response_steps_q;
	logic [AW_W-1:0] recovery_per_tick_q;
	logic [AW_W-1:0] initial_awareness_q;
	logic [15:0]     decel_per_tick_q;
	logic            start_automated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_steps_q    <= 16'd50;
			recovery_per_tick_q <= AW_W'(655);
			initial_awareness_q <= AW_W'(32768);
			decel_per_tick_q    <= 16'd15;
			start_automated_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RESPONSE_STEPS:    response_steps_q    <= cfg_wdata[15:0];
				CFG_RECOVERY_PER_TICK: recovery_per_tick_q <= cfg_wdata[AW_W-1:0];
				CFG_INITIAL_AWARENESS: initial_awareness_q <= cfg_wdata[AW_W-1:0];
				CFG_DECEL_PER_TICK:    decel_per_tick_q    <= cfg_wdata[15:0];
				CFG_START_AUTOMATED:   start_automated_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.response_steps    = response_steps_q;
		cfg.recovery_per_tick = recovery_per_tick_q;
		cfg.initial_awareness = initial_awareness_q;
		cfg.decel_per_tick    = decel_per_tick_q;
		cfg.start_automated   = start_automated_q;
		// writing the start mode restarts the supervisor at once
		cfg.restart           = cfg_we && (cfg_index == CFG_START_AUTOMATED);
		cfg.restart_auto      = cfg_wdata[0];
	end

endmodule

>>> sv/tcs_core.sv
// supervisor state and the single-pass update for one word
module tcs_core
	import tcs_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tcs_cfg_t cfg,
	input  logic     fire,
	input  tcs_in_t  item,
	output tcs_out_t result
);

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [CW-1:0] TMR_MAX = CW'({TIMER_BITS{1'b1}});

	mode_t                 mode_q, n_mode;
	logic [AW_W-1:0]       aw_q, n_aw;
	logic [TIMER_BITS-1:0] tt_q, n_tt, bt_q, n_bt;
	logic                  tp_q, n_tp, bp_q, n_bp;
	logic                  warn_c, cmd_v_c;
	logic [15:0]           cmd_c;
	logic [AW_W:0]         aw_sum;
	logic [TIMER_BITS-1:0] resp_clamped, ttb_clamped;

	function automatic logic [TIMER_BITS-1:0] clamp_timer(input logic [15:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		clamp_timer = (w > TMR_MAX) ? {TIMER_BITS{1'b1}} : TIMER_BITS'(w);
	endfunction

	assign aw_sum       = {1'b0, aw_q} + {1'b0, cfg.recovery_per_tick};
	assign resp_clamped = clamp_timer(cfg.response_steps);
	assign ttb_clamped  = clamp_timer(item.time_till_brake);

	// next state, in the order a tick resolves: mode action, braking, takeover
	always_comb begin
		n_mode  = mode_q;
		n_aw    = aw_q;
		n_tt    = tt_q;
		n_tp    = tp_q;
		n_bt    = bt_q;
		n_bp    = bp_q;
		warn_c  = 1'b0;
		cmd_v_c = 1'b0;
		cmd_c   = '0;
		unique case (item.opcode)
			OP_TICK: begin
				if (mode_q == MODE_BRAKE) begin
					cmd_v_c = 1'b1;
					cmd_c   = (item.current_speed > cfg.decel_per_tick) ?
						item.current_speed - cfg.decel_per_tick : '0;
				end else if (mode_q == MODE_RECOVER) begin
					if (aw_q < AW_ONE)
						n_aw = (aw_sum > {1'b0, AW_ONE}) ? AW_ONE : aw_sum[AW_W-1:0];
					if (n_aw == AW_ONE)
						n_mode = MODE_MANUAL;
				end
				if (bp_q) begin
					if (bt_q <= TIMER_BITS'(1)) begin
						n_bp   = 1'b0;
						n_bt   = '0;
						n_mode = MODE_BRAKE;
						n_aw   = AW_ONE;
					end else begin
						n_bt = bt_q - TIMER_BITS'(1);
					end
				end
				if (tp_q) begin
					if (tt_q <= TIMER_BITS'(1)) begin
						n_tp   = 1'b0;
						n_tt   = '0;
						n_bp   = 1'b0;
						n_bt   = '0;
						warn_c = cfg.initial_awareness > AW_ONE;
						n_aw   = warn_c ? AW_ONE : cfg.initial_awareness;
						n_mode = MODE_RECOVER;
					end else begin
						n_tt = tt_q - TIMER_BITS'(1);
					end
				end
			end
			OP_TAKEOVER: begin
				if (mode_q == MODE_AUTO) begin
					n_tp = 1'b1;
					n_tt = resp_clamped;
					if (cfg.response_steps > item.time_till_brake) begin
						n_bp = 1'b1;
						n_bt = ttb_clamped;
					end
					n_mode = MODE_PREP;
				end else begin
					// upward request: back to automated, a nonzero time field only raises the warning
					warn_c = item.time_till_brake != 16'd0;
					n_mode = MODE_AUTO;
					n_aw   = AW_ONE;
					n_tp   = 1'b0;
					n_tt   = '0;
					n_bp   = 1'b0;
					n_bt   = '0;
				end
			end
			OP_BRAKE: begin
				n_tp   = 1'b0;
				n_tt   = '0;
				n_bp   = 1'b0;
				n_bt   = '0;
				n_mode = MODE_BRAKE;
				n_aw   = AW_ONE;
			end
			OP_SET_AW: begin
				warn_c = item.awareness_value > AW_ONE;
				n_aw   = warn_c ? AW_ONE : item.awareness_value;
			end
		endcase
	end

	always_comb begin
		result.mode            = n_mode;
		result.awareness       = n_aw;
		result.automated_type  = (n_mode == MODE_AUTO) || (n_mode == MODE_PREP) ||
			(n_mode == MODE_BRAKE);
		result.speed_cmd_valid = cmd_v_c;
		result.speed_cmd       = cmd_c;
		result.warning         = warn_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_AUTO;
			aw_q   <= AW_ONE;
			tt_q   <= '0;
			tp_q   <= 1'b0;
			bt_q   <= '0;
			bp_q   <= 1'b0;
		end else if (cfg.restart) begin
			mode_q <= cfg.restart_auto ? MODE_AUTO : MODE_MANUAL;
			aw_q   <= AW_ONE;
			tt_q   <= '0;
			tp_q   <= 1'b0;
			bt_q   <= '0;
			bp_q   <= 1'b0;
		end else if (fire) begin
			mode_q <= n_mode;
			aw_q   <= n_aw;
			tt_q   <= n_tt;
			tp_q   <= n_tp;
			bt_q   <= n_bt;
			bp_q   <= n_bp;
		end
	end

endmodule

>>> sv/takeover_control_supervisor_top.sv
// a word accepted into the input register has its result word registered in the output register when it advances
// throughput: one word per cycle while the output is not stalled, set by the single-pass state update
// an input register and an output register let a new word in while a result waits
// reset: mode automated, awareness one, countdowns cleared, config at defaults
// a write of the start mode register restarts the mode in the same cycle
`include "takeover_control_supervisor_top_defines.svh"
module takeover_control_supervisor_top
	import tcs_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcs_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tcs_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	tcs_cfg_t cfg;
	logic     valid_s1;
	tcs_in_t  item_s1;
	logic     advance;
	tcs_out_t result;
	logic     out_valid_q;
	tcs_out_t out_data_q;

	tcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tcs_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// the held word moves on when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TCS_ASSERT(a_stall_only_when_full, !in_ready |-> (valid_s1 && out_valid_q && !out_ready), "input stalled without a full pipeline")
	`TCS_ASSERT(a_awareness_range, out_valid |-> (out_data.awareness <= AW_ONE), "awareness above one")
	`TCS_ASSERT(a_cmd_zero_when_idle, (out_valid && !out_data.speed_cmd_valid) |-> (out_data.speed_cmd == 16'd0), "speed command without valid")
	`TCS_ASSERT(a_auto_type, out_valid |-> (out_data.automated_type == ((out_data.mode == MODE_AUTO) || (out_data.mode == MODE_PREP) || (out_data.mode == MODE_BRAKE))), "automated type disagrees with mode")
	`TCS_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!out_valid && !valid_s1), "pipeline not empty in reset")

endmodule
